// File: rtl/core/bc2d_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc2d_pkg
// Shared constants for the 2D barycentric weight core and its checker.
// ----------------------------------------------------------------------------
package bc2d_pkg;

  // Default coordinate width (signed integer corners and point)
  localparam int COORD_BITS_DEFAULT = 16;
  // Default number of fraction bits in the weights
  localparam int FRAC_BITS_DEFAULT  = 24;

  // Weight field width (signed, saturated)
  localparam int WEIGHT_W = 32;
  // Quotient bits produced by the divider: one below the weight width
  localparam int Q_BITS   = WEIGHT_W - 1;

  // Degenerate threshold register
  localparam int                  THRESH_W     = 35;
  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

  // Saturation bounds of a weight
  localparam logic signed [WEIGHT_W-1:0] W_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] W_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

endpackage

// File: rtl/core/barycentric_coords_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barycentric_coords_2d_core
// Barycentric weights of a query point with respect to a 2D triangle.
// ----------------------------------------------------------------------------
// Fully pipelined: one beat enters per cycle while in_stall is low, and every
// beat gives exactly one result beat (5 front stages for differences, products,
// determinant, magnitudes and divider setup, 31 restoring divider stages
// producing one quotient bit each for both weights, then saturation and the
// third weight). The pipeline length is set by the 31 quotient bits of the
// divider. Stalls ripple back only as far as the first empty stage, so the
// core keeps taking beats while a finished result waits at the output.
// degenerate_threshold is written through cfg_we/cfg_data; a triangle whose
// |det| is below it, or whose det is zero, reports degenerate with zero
// weights. Weights are signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module barycentric_coords_2d_core #(
  parameter int COORD_BITS = bc2d_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = bc2d_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,

  // Configuration
  input  logic                                 cfg_we,
  input  logic [bc2d_pkg::THRESH_W-1:0]        cfg_data,

  // Input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [COORD_BITS-1:0]         first_x,
  input  logic signed [COORD_BITS-1:0]         first_y,
  input  logic signed [COORD_BITS-1:0]         second_x,
  input  logic signed [COORD_BITS-1:0]         second_y,
  input  logic signed [COORD_BITS-1:0]         third_x,
  input  logic signed [COORD_BITS-1:0]         third_y,
  input  logic signed [COORD_BITS-1:0]         point_x,
  input  logic signed [COORD_BITS-1:0]         point_y,

  // Output channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_first,
  output logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_second,
  output logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_third,
  output logic                                 degenerate
);

  localparam int WEIGHT_W = bc2d_pkg::WEIGHT_W;
  localparam int Q_BITS   = bc2d_pkg::Q_BITS;
  localparam int THRESH_W = bc2d_pkg::THRESH_W;

  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int DET_W  = PROD_W + 1;
  localparam int CMP_W  = (DET_W > THRESH_W) ? DET_W : THRESH_W;
  localparam int INT_SH = Q_BITS - FRAC_BITS;
  localparam int EXT_W  = DET_W + Q_BITS;
  localparam int SUM_W  = WEIGHT_W + 2;

  // Stage numbering
  localparam int S_DIFF = 0;
  localparam int S_PROD = 1;
  localparam int S_DET  = 2;
  localparam int S_MAG  = 3;
  localparam int S_INIT = 4;
  localparam int S_DIV0 = 5;
  localparam int S_SAT  = S_DIV0 + Q_BITS;
  localparam int S_OUT  = S_SAT + 1;
  localparam int NSTG   = S_OUT + 1;

  localparam logic signed [SUM_W-1:0] ONE_FX = SUM_W'(1) <<< FRAC_BITS;

  // ---------------------------------------------------------------------------
  // Threshold register
  // ---------------------------------------------------------------------------
  logic [THRESH_W-1:0] thresh;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= bc2d_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thresh <= cfg_data;
    end
  end

  // ---------------------------------------------------------------------------
  // Valid bits and stage enables
  // A stage loads when some stage at or after it is empty, or the output moves.
  // ---------------------------------------------------------------------------
  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] vld_in;
  logic [NSTG-1:0] vbar;
  logic [NSTG-1:0] en;

  assign vld_in = {vld[NSTG-2:0], in_valid};
  assign vbar   = ~vld;

  for (genvar k = 0; k < NSTG; k++) begin : g_en
    assign en[k] = !out_stall || (|vbar[NSTG-1:k]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) vld[k] <= vld_in[k];
      end
    end
  end

  assign in_stall  = !en[S_DIFF];
  assign out_valid = vld[S_OUT];

  // ---------------------------------------------------------------------------
  // Stage 0: edge vectors relative to the third corner
  // ---------------------------------------------------------------------------
  logic signed [DIFF_W-1:0] ax, ay, bx, by, cx, cy;

  always_ff @(posedge clk) begin
    if (en[S_DIFF]) begin
      ax <= DIFF_W'(first_x)  - DIFF_W'(third_x);
      ay <= DIFF_W'(first_y)  - DIFF_W'(third_y);
      bx <= DIFF_W'(second_x) - DIFF_W'(third_x);
      by <= DIFF_W'(second_y) - DIFF_W'(third_y);
      cx <= DIFF_W'(point_x)  - DIFF_W'(third_x);
      cy <= DIFF_W'(point_y)  - DIFF_W'(third_y);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: cross products
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] p_axby, p_bxay, p_bycx, p_bxcy, p_axcy, p_aycx;

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      p_axby <= ax * by;
      p_bxay <= bx * ay;
      p_bycx <= by * cx;
      p_bxcy <= bx * cy;
      p_axcy <= ax * cy;
      p_aycx <= ay * cx;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: determinant and the two numerators
  // ---------------------------------------------------------------------------
  logic signed [DET_W-1:0] det, num1, num2;

  always_ff @(posedge clk) begin
    if (en[S_DET]) begin
      det  <= DET_W'(p_axby) - DET_W'(p_bxay);
      num1 <= DET_W'(p_bycx) - DET_W'(p_bxcy);
      num2 <= DET_W'(p_axcy) - DET_W'(p_aycx);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: magnitudes, quotient signs, degenerate decision
  // ---------------------------------------------------------------------------
  logic [DET_W-1:0] det_mag, n1_mag, n2_mag;
  logic             neg1_m, neg2_m, degen_m;
  logic [DET_W-1:0] det_abs, n1_abs, n2_abs;

  assign det_abs = det[DET_W-1]  ? DET_W'(-det)  : DET_W'(det);
  assign n1_abs  = num1[DET_W-1] ? DET_W'(-num1) : DET_W'(num1);
  assign n2_abs  = num2[DET_W-1] ? DET_W'(-num2) : DET_W'(num2);

  always_ff @(posedge clk) begin
    if (en[S_MAG]) begin
      det_mag <= det_abs;
      n1_mag  <= n1_abs;
      n2_mag  <= n2_abs;
      neg1_m  <= num1[DET_W-1] ^ det[DET_W-1];
      neg2_m  <= num2[DET_W-1] ^ det[DET_W-1];
      degen_m <= (det == '0) || (CMP_W'(det_abs) < CMP_W'(thresh));
    end
  end

  // ---------------------------------------------------------------------------
  // Divider pipeline storage; index 0 is the setup stage, j+1 after step j
  // ---------------------------------------------------------------------------
  logic [DET_W-1:0]  dv    [0:Q_BITS];
  logic [DET_W-1:0]  r1    [0:Q_BITS];
  logic [DET_W-1:0]  r2    [0:Q_BITS];
  logic [Q_BITS-1:0] q1    [0:Q_BITS];
  logic [Q_BITS-1:0] q2    [0:Q_BITS];
  logic [Q_BITS-1:0] lo1   [0:Q_BITS];
  logic [Q_BITS-1:0] lo2   [0:Q_BITS];
  logic              ovf1  [0:Q_BITS];
  logic              ovf2  [0:Q_BITS];
  logic              neg1  [0:Q_BITS];
  logic              neg2  [0:Q_BITS];
  logic              degen [0:Q_BITS];

  // ---------------------------------------------------------------------------
  // Stage 4: split numerators into leading remainder and bits still to shift
  // in; the integer part overflows when the leading remainder reaches |det|
  // ---------------------------------------------------------------------------
  logic [EXT_W-1:0] n1_ext, n2_ext, n1_lsh, n2_lsh;
  logic [DET_W-1:0] r1_init, r2_init;

  assign n1_ext  = EXT_W'(n1_mag);
  assign n2_ext  = EXT_W'(n2_mag);
  assign n1_lsh  = n1_ext << FRAC_BITS;
  assign n2_lsh  = n2_ext << FRAC_BITS;
  assign r1_init = DET_W'(n1_ext >> INT_SH);
  assign r2_init = DET_W'(n2_ext >> INT_SH);

  always_ff @(posedge clk) begin
    if (en[S_INIT]) begin
      dv[0]    <= det_mag;
      r1[0]    <= r1_init;
      r2[0]    <= r2_init;
      q1[0]    <= '0;
      q2[0]    <= '0;
      lo1[0]   <= n1_lsh[Q_BITS-1:0];
      lo2[0]   <= n2_lsh[Q_BITS-1:0];
      ovf1[0]  <= (r1_init >= det_mag);
      ovf2[0]  <= (r2_init >= det_mag);
      neg1[0]  <= neg1_m;
      neg2[0]  <= neg2_m;
      degen[0] <= degen_m;
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5..35: restoring division, one quotient bit per stage per weight
  // ---------------------------------------------------------------------------
  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    logic [DET_W:0] t1, t2, d_ext;
    logic           ge1, ge2;

    assign d_ext = {1'b0, dv[j]};
    assign t1    = {r1[j], lo1[j][Q_BITS-1-j]};
    assign t2    = {r2[j], lo2[j][Q_BITS-1-j]};
    assign ge1   = (t1 >= d_ext);
    assign ge2   = (t2 >= d_ext);

    always_ff @(posedge clk) begin
      if (en[S_DIV0+j]) begin
        dv[j+1]    <= dv[j];
        r1[j+1]    <= ge1 ? DET_W'(t1 - d_ext) : DET_W'(t1);
        r2[j+1]    <= ge2 ? DET_W'(t2 - d_ext) : DET_W'(t2);
        q1[j+1]    <= {q1[j][Q_BITS-2:0], ge1};
        q2[j+1]    <= {q2[j][Q_BITS-2:0], ge2};
        lo1[j+1]   <= lo1[j];
        lo2[j+1]   <= lo2[j];
        ovf1[j+1]  <= ovf1[j];
        ovf2[j+1]  <= ovf2[j];
        neg1[j+1]  <= neg1[j];
        neg2[j+1]  <= neg2[j];
        degen[j+1] <= degen[j];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 36: apply sign and saturate the first two weights
  // ---------------------------------------------------------------------------
  logic signed [WEIGHT_W-1:0] w1_s, w2_s, w1_n, w2_n;
  logic                       degen_s;

  always_comb begin
    if (ovf1[Q_BITS]) begin
      w1_n = neg1[Q_BITS] ? bc2d_pkg::W_MIN : bc2d_pkg::W_MAX;
    end else if (neg1[Q_BITS]) begin
      w1_n = -$signed({1'b0, q1[Q_BITS]});
    end else begin
      w1_n = $signed({1'b0, q1[Q_BITS]});
    end
    if (ovf2[Q_BITS]) begin
      w2_n = neg2[Q_BITS] ? bc2d_pkg::W_MIN : bc2d_pkg::W_MAX;
    end else if (neg2[Q_BITS]) begin
      w2_n = -$signed({1'b0, q2[Q_BITS]});
    end else begin
      w2_n = $signed({1'b0, q2[Q_BITS]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_SAT]) begin
      w1_s    <= w1_n;
      w2_s    <= w2_n;
      degen_s <= degen[Q_BITS];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 37: third weight, degenerate override, output register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]    w3_sum;
  logic signed [WEIGHT_W-1:0] w3_sat;

  assign w3_sum = ONE_FX - SUM_W'(w1_s) - SUM_W'(w2_s);

  always_comb begin
    if (w3_sum > SUM_W'(bc2d_pkg::W_MAX)) begin
      w3_sat = bc2d_pkg::W_MAX;
    end else if (w3_sum < SUM_W'(bc2d_pkg::W_MIN)) begin
      w3_sat = bc2d_pkg::W_MIN;
    end else begin
      w3_sat = WEIGHT_W'(w3_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      weight_first  <= degen_s ? '0 : w1_s;
      weight_second <= degen_s ? '0 : w2_s;
      weight_third  <= degen_s ? '0 : w3_sat;
      degenerate    <= degen_s;
    end
  end

endmodule

// File: rtl/core/bc2d_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bc2d_checker
// Port-level checks for the barycentric weight core, bound to the top level.
// ----------------------------------------------------------------------------
module bc2d_checker #(
  parameter int COORD_BITS = bc2d_pkg::COORD_BITS_DEFAULT,
  parameter int FRAC_BITS  = bc2d_pkg::FRAC_BITS_DEFAULT
) (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic signed [COORD_BITS-1:0]         first_x,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_first,
  input logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_second,
  input logic signed [bc2d_pkg::WEIGHT_W-1:0] weight_third,
  input logic                                 degenerate
);

  localparam logic signed [bc2d_pkg::WEIGHT_W-1:0] ONE_W =
    bc2d_pkg::WEIGHT_W'(1) <<< FRAC_BITS;

  // A degenerate triangle carries all-zero weights
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |->
      weight_first == '0 && weight_second == '0 && weight_third == '0)
    else $error("degenerate beat with nonzero weight");

  // With the first two weights zero the third is exactly one
  a_third_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate && weight_first == '0 && weight_second == '0 |->
      weight_third == ONE_W)
    else $error("third weight not one when the others are zero");

  // An empty output stage never pushes back on the input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage empty");

  // A stalled input beat stays offered, with first_x unchanged
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(first_x))
    else $error("stalled input beat changed");

  // A waiting result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=>
      out_valid && $stable(weight_first) && $stable(weight_second) &&
      $stable(weight_third) && $stable(degenerate))
    else $error("stalled output beat changed");

endmodule

bind barycentric_coords_2d_core bc2d_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_bc2d_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_stall      (in_stall),
  .first_x       (first_x),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .weight_first  (weight_first),
  .weight_second (weight_second),
  .weight_third  (weight_third),
  .degenerate    (degenerate)
);

// File: verif/tb_barycentric_coords_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_barycentric_coords_2d_core
// Self-checking bench for the 2D barycentric weight core. A table of
// hand-picked triangles runs first: unit and full-range triangles, both signs
// of the determinant, collinear and coincident corners, and weights at and past
// the saturation edge. Random triangles follow under several degenerate
// thresholds. Each accepted input beat is scored by its pinned weights or a
// local fixed-point predictor; output beats match in order. Both channels idle
// at random, and one long output hold backs the pipeline up into the input.
// ----------------------------------------------------------------------------
module tb_barycentric_coords_2d_core;

  localparam int CW           = bc2d_pkg::COORD_BITS_DEFAULT;
  localparam int FB           = bc2d_pkg::FRAC_BITS_DEFAULT;
  localparam int WEIGHT_W     = bc2d_pkg::WEIGHT_W;
  localparam int Q_BITS       = bc2d_pkg::Q_BITS;
  localparam int THRESH_W     = bc2d_pkg::THRESH_W;
  localparam logic [THRESH_W-1:0]        THRESH_RESET = bc2d_pkg::THRESH_RESET;
  localparam logic signed [WEIGHT_W-1:0] W_MAX        = bc2d_pkg::W_MAX;
  localparam logic signed [WEIGHT_W-1:0] W_MIN        = bc2d_pkg::W_MIN;
  localparam int ONE_Q        = 1 << FB;
  localparam int PHASES       = 7;
  localparam int PHASE_ITEMS  = 255;
  localparam int HOLD_AT      = 40;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic signed [CW-1:0] fx, fy, sx, sy, tx, ty, px, py;
  } tri_query_t;

  typedef struct packed {
    logic signed [WEIGHT_W-1:0] w_first, w_second, w_third;
    logic                       degen;
  } bary_weights_t;

  typedef struct {
    tri_query_t    q;
    bit            pinned;
    bary_weights_t w;
  } vector_row_t;

  // DUT signals; the ones the bench drives are known from time zero
  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_we    = 1'b0;
  logic [THRESH_W-1:0]        cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [CW-1:0]       first_x   = '0;
  logic signed [CW-1:0]       first_y   = '0;
  logic signed [CW-1:0]       second_x  = '0;
  logic signed [CW-1:0]       second_y  = '0;
  logic signed [CW-1:0]       third_x   = '0;
  logic signed [CW-1:0]       third_y   = '0;
  logic signed [CW-1:0]       point_x   = '0;
  logic signed [CW-1:0]       point_y   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [WEIGHT_W-1:0] weight_first;
  logic signed [WEIGHT_W-1:0] weight_second;
  logic signed [WEIGHT_W-1:0] weight_third;
  logic                       degenerate;

  // Bench state
  bary_weights_t       expected_weights[$];
  vector_row_t         vectors[$];
  logic [THRESH_W-1:0] thr_now      = THRESH_RESET;
  bit                  pin_valid    = 1'b0;
  bary_weights_t       pin_weights  = '0;
  bit                  steady       = 1'b0;
  int                  mismatch_count = 0;
  int                  stuck_cycles   = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  barycentric_coords_2d_core #(
    .COORD_BITS (CW),
    .FRAC_BITS  (FB)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .first_x       (first_x),
    .first_y       (first_y),
    .second_x      (second_x),
    .second_y      (second_y),
    .third_x       (third_x),
    .third_y       (third_y),
    .point_x       (point_x),
    .point_y       (point_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .weight_first  (weight_first),
    .weight_second (weight_second),
    .weight_third  (weight_third),
    .degenerate    (degenerate)
  );

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic longint clamp_weight(longint x);
    if (x > longint'(W_MAX)) return longint'(W_MAX);
    if (x < longint'(W_MIN)) return longint'(W_MIN);
    return x;
  endfunction

  // num/den truncated toward zero to FB fraction bits; an integer part too
  // wide for the weight saturates
  function automatic longint fixed_ratio(longint num, longint den);
    longint unsigned n, d, mag;
    n = (num < 0) ? -num : num;
    d = (den < 0) ? -den : den;
    if (((n / d) >> (Q_BITS - FB)) != 0) mag = 64'd1 << WEIGHT_W;
    else mag = (n << FB) / d;
    return clamp_weight(((num < 0) != (den < 0)) ? -longint'(mag) : longint'(mag));
  endfunction

  function automatic bary_weights_t barycentric_weights(tri_query_t q,
                                                        logic [THRESH_W-1:0] thr);
    longint ax, ay, bx, by, cx, cy, det, w1, w2, w3;
    longint unsigned det_mag;
    bary_weights_t r;
    ax = longint'($signed(q.fx)) - longint'($signed(q.tx));
    ay = longint'($signed(q.fy)) - longint'($signed(q.ty));
    bx = longint'($signed(q.sx)) - longint'($signed(q.tx));
    by = longint'($signed(q.sy)) - longint'($signed(q.ty));
    cx = longint'($signed(q.px)) - longint'($signed(q.tx));
    cy = longint'($signed(q.py)) - longint'($signed(q.ty));
    det = ax * by - bx * ay;
    det_mag = (det < 0) ? -det : det;
    r = '0;
    // zero det is degenerate whatever the threshold
    if (det == 0 || det_mag < 64'(thr)) begin
      r.degen = 1'b1;
      return r;
    end
    w1 = fixed_ratio(by * cx - bx * cy, det);
    w2 = fixed_ratio(ax * cy - ay * cx, det);
    // third weight from the already saturated pair
    w3 = clamp_weight((longint'(1) << FB) - w1 - w2);
    r.w_first  = w1[WEIGHT_W-1:0];
    r.w_second = w2[WEIGHT_W-1:0];
    r.w_third  = w3[WEIGHT_W-1:0];
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic tri_query_t tri_q(int fx, int fy, int sx, int sy,
                                       int tx, int ty, int px, int py);
    tri_query_t q;
    q.fx = CW'(fx); q.fy = CW'(fy);
    q.sx = CW'(sx); q.sy = CW'(sy);
    q.tx = CW'(tx); q.ty = CW'(ty);
    q.px = CW'(px); q.py = CW'(py);
    return q;
  endfunction

  function automatic bary_weights_t wts(int w1, int w2, int w3, bit dg);
    bary_weights_t w;
    w.w_first  = w1;
    w.w_second = w2;
    w.w_third  = w3;
    w.degen    = dg;
    return w;
  endfunction

  task automatic add_vector(tri_query_t q, bit pinned, bary_weights_t w);
    vector_row_t row;
    row.q      = q;
    row.pinned = pinned;
    row.w      = w;
    vectors.push_back(row);
  endtask

  function automatic int rnd(int r);
    return int'($urandom_range(0, 2 * r)) - r;
  endfunction

  // Random triangle of one of several shapes
  function automatic tri_query_t random_query();
    int v[8];
    int kind, r, k, c, dx, dy, m1, m2;
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2: begin
        for (k = 0; k < 8; k++) v[k] = int'($urandom);
      end
      3, 4, 5: begin
        case ($urandom_range(0, 3))
          0:       r = 3;
          1:       r = 40;
          2:       r = 700;
          default: r = 20000;
        endcase
        for (k = 0; k < 8; k++) v[k] = rnd(r);
      end
      6: begin
        // point on or next to one corner
        for (k = 0; k < 6; k++) v[k] = rnd(40);
        c = $urandom_range(0, 2);
        v[6] = v[2*c] + rnd(2);
        v[7] = v[2*c+1] + rnd(2);
      end
      7: begin
        // collinear or repeated corners
        v[4] = rnd(1000); v[5] = rnd(1000);
        dx = rnd(300); dy = rnd(300);
        m1 = rnd(3); m2 = rnd(3);
        v[0] = v[4] + m1 * dx; v[1] = v[5] + m1 * dy;
        v[2] = v[4] + m2 * dx; v[3] = v[5] + m2 * dy;
        v[6] = rnd(1000); v[7] = rnd(1000);
      end
      8: begin
        for (k = 0; k < 8; k++) begin
          case ($urandom_range(0, 6))
            0:       v[k] = -32768;
            1:       v[k] = -32767;
            2:       v[k] = -1;
            3:       v[k] = 0;
            4:       v[k] = 1;
            5:       v[k] = 32766;
            default: v[k] = 32767;
          endcase
        end
      end
      default: begin
        // right triangle, leg lengths spread over many octaves of det
        v[4] = rnd(2000); v[5] = rnd(2000);
        v[0] = v[4] + rnd(1 << $urandom_range(0, 14)); v[1] = v[5];
        v[2] = v[4]; v[3] = v[5] + rnd(1 << $urandom_range(0, 14));
        v[6] = v[4] + rnd(1 << $urandom_range(0, 14));
        v[7] = v[5] + rnd(1 << $urandom_range(0, 14));
      end
    endcase
    return tri_q(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
  endfunction

  // Offer one input beat, after a random gap unless steady, and wait for it to be taken
  task automatic offer_beat(tri_query_t q, bit pinned, bary_weights_t w);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    first_x     <= q.fx;
    first_y     <= q.fy;
    second_x    <= q.sx;
    second_y    <= q.sy;
    third_x     <= q.tx;
    third_y     <= q.ty;
    point_x     <= q.px;
    point_y     <= q.py;
    pin_valid   <= pinned;
    pin_weights <= w;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // --------------------------------------------------------------------------
  // Input side: directed table, then random phases under new thresholds
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int phase, i, k;
    logic [THRESH_W-1:0] thr_next;

    // degenerate: all corners at the origin, collinear, coincident
    add_vector(tri_q(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, wts(0, 0, 0, 1'b1));
    add_vector(tri_q(1, 1, 2, 2, 0, 0, 5, -3), 1'b1, wts(0, 0, 0, 1'b1));
    add_vector(tri_q(32767, -32768, 32767, -32768, 32767, -32768, 0, 0), 1'b1,
               wts(0, 0, 0, 1'b1));
    // unit triangle, |det| equal to the reset threshold, point on each corner
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 0, 0), 1'b1, wts(0, 0, ONE_Q, 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 1, 0), 1'b1, wts(ONE_Q, 0, 0, 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 0, 1), 1'b1, wts(0, ONE_Q, 0, 1'b0));
    // negative determinant
    add_vector(tri_q(0, 1, 1, 0, 0, 0, 0, 1), 1'b1, wts(ONE_Q, 0, 0, 1'b0));
    // full-range triangle, point on each corner
    add_vector(tri_q(32767, -32768, -32768, 32767, -32768, -32768, -32768, -32768),
               1'b1, wts(0, 0, ONE_Q, 1'b0));
    add_vector(tri_q(32767, -32768, -32768, 32767, -32768, -32768, 32767, -32768),
               1'b1, wts(ONE_Q, 0, 0, 1'b0));
    add_vector(tri_q(32767, -32768, -32768, 32767, -32768, -32768, -32768, 32767),
               1'b1, wts(0, ONE_Q, 0, 1'b0));
    // last integer part that fits, then saturation on either side
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 127, 0), 1'b1,
               wts(127 << FB, 0, ONE_Q - (127 << FB), 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 128, 0), 1'b1,
               wts(int'(W_MAX), 0, ONE_Q - int'(W_MAX), 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, -128, 0), 1'b1,
               wts(int'(W_MIN), 0, int'(W_MAX), 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 32767, -32768), 1'b1,
               wts(int'(W_MAX), int'(W_MIN), ONE_Q + 1, 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, -200, -200), 1'b1,
               wts(int'(W_MIN), int'(W_MIN), int'(W_MAX), 1'b0));
    add_vector(tri_q(1, 0, 0, 1, 0, 0, 200, 200), 1'b1,
               wts(int'(W_MAX), int'(W_MAX), int'(W_MIN), 1'b0));
    // fractions and truncation toward zero, scored by the predictor
    add_vector(tri_q(3, 0, 0, 3, 0, 0, 1, 1), 1'b0, '0);
    add_vector(tri_q(3, 0, 0, 3, 0, 0, -1, -1), 1'b0, '0);
    add_vector(tri_q(3, 0, 0, 3, 0, 0, 2, -1), 1'b0, '0);
    add_vector(tri_q(0, 7, 7, 0, 0, 0, 3, 2), 1'b0, '0);
    add_vector(tri_q(1, 0, 0, 1, 0, 0, -127, -1), 1'b0, '0);
    add_vector(tri_q(32767, -32768, -32768, 32767, -32768, -32768, -32767, -32768),
               1'b0, '0);
    add_vector(tri_q(-32768, -32768, 32767, 32767, -32768, 32767, 0, 0), 1'b0, '0);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < vectors.size(); k++) offer_beat(vectors[k].q, vectors[k].pinned,
                                                    vectors[k].w);

    for (phase = 0; phase < PHASES; phase++) begin
      // threshold changes only with the pipeline empty
      if (phase > 0) begin
        while (expected_weights.size() != 0) @(posedge clk);
        case (phase)
          1:       thr_next = '0;
          2:       thr_next = '1;
          3:       thr_next = THRESH_W'(64'd1 << 34);
          4:       thr_next = THRESH_W'($urandom_range(2, 65536));
          5:       thr_next = THRESH_W'({$urandom_range(0, 1), $urandom});
          default: thr_next = THRESH_RESET;
        endcase
        cfg_we   <= 1'b1;
        cfg_data <= thr_next;
        @(posedge clk);
        cfg_we   <= 1'b0;
        thr_now = thr_next;
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        // first stretch of phase 0 runs gap-free so the long hold backs up
        if (i % 60 == 0) steady = (phase == 0 && i < 180) || ($urandom_range(0, 3) == 0);
        offer_beat(random_query(), 1'b0, '0);
      end
      in_valid <= 1'b0;
      @(posedge clk);
    end

    while (expected_weights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_weights.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int hold, taken;
    taken = 0;
    while (rst) @(posedge clk);
    forever begin
      if (taken == HOLD_AT) hold = HOLD_CYCLES;
      else hold = steady ? 0 : $urandom_range(0, 11);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard: predict on input beats, match output beats in order
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    tri_query_t    q;
    bary_weights_t exp_w, got_w;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        q.fx = first_x;  q.fy = first_y;
        q.sx = second_x; q.sy = second_y;
        q.tx = third_x;  q.ty = third_y;
        q.px = point_x;  q.py = point_y;
        expected_weights.push_back(pin_valid ? pin_weights : barycentric_weights(q, thr_now));
      end
      if (out_valid && !out_stall) begin
        got_w.w_first  = weight_first;
        got_w.w_second = weight_second;
        got_w.w_third  = weight_third;
        got_w.degen    = degenerate;
        if (expected_weights.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: unexpected result beat w1=%0d w2=%0d w3=%0d degenerate=%0b",
                     got_w.w_first, got_w.w_second, got_w.w_third, got_w.degen);
        end else begin
          exp_w = expected_weights.pop_front();
          if (got_w.w_first !== exp_w.w_first || got_w.w_second !== exp_w.w_second ||
              got_w.w_third !== exp_w.w_third || got_w.degen !== exp_w.degen) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
              $display(
                "ERROR: exp w1=%0d w2=%0d w3=%0d dg=%0b got w1=%0d w2=%0d w3=%0d dg=%0b",
                exp_w.w_first, exp_w.w_second, exp_w.w_third, exp_w.degen,
                got_w.w_first, got_w.w_second, got_w.w_third, got_w.degen);
          end
        end
      end
    end
  end

  // Watchdog: too long without any beat moving on either channel
  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

endmodule

// File: files.f
rtl/core/bc2d_pkg.sv
rtl/core/barycentric_coords_2d_core.sv
rtl/core/bc2d_checker.sv
verif/tb_barycentric_coords_2d_core.sv
